/* hdl/lru_replacement_policy_macros.svh */
// assertion macros for the lru replacement policy block
`ifndef LRU_REPLACEMENT_POLICY_MACROS_SVH
`define LRU_REPLACEMENT_POLICY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LRURP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru policy check failed");

// antecedent implies consequent in the next cycle
`define LRURP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru policy check failed");

`endif

/* hdl/lrurp_pkg.sv */
// types and constants shared by the lru replacement policy modules
`timescale 1ns / 1ps
package lrurp_pkg;

  localparam int unsigned WayW       = 4;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned MaxWaysDef = 16;
  localparam int unsigned ResetWays  = 16;

  typedef logic [WayW-1:0] way_t;
  typedef logic [CfgW-1:0] cfg_t;

  typedef enum logic {
    OpTouch = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    op_e  operation;
    way_t way;
  } in_item_t;

  typedef struct packed {
    way_t victim;
    logic from_empty;
    logic bad_way;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
    way_t way;
  } cell_ctrl_t;

endpackage

/* hdl/lru_replacement_policy.sv */
// true lru victim selection for one cache set, built as a row of list cells
//
// channels: in_valid_i/in_ready_o/in_data_i carry touch or query items,
// out_valid_o/out_ready_i/out_data_o carry one result item per input item,
// cfg_valid_i/cfg_ready_o/cfg_data_i write the ways register and empty the list.
// a touch enters at cell 0; every cell up to the hit or the first empty cell
// loads its neighbor's way in the same cycle, so the whole list updates together.
// order: the list updates at the accepting edge, and the victim lookup for the
// item is then registered into the output register.
// throughput: one item per cycle while the output is taken and no config waits;
// the list update at the accepting edge and the registered victim stage set this figure.
// stall: a held result keeps the lookup stage full; one more item is accepted
// into it, then in_ready_o drops until the output is taken.
// config is taken only with the lookup stage empty and blocks input while it waits.
// reset: list empty, ways = 16 (clamped to MAX_WAYS), no result pending.
`timescale 1ns / 1ps
module lru_replacement_policy #(
  parameter int unsigned MAX_WAYS = lrurp_pkg::MaxWaysDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lrurp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lrurp_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  lrurp_pkg::cfg_t      cfg_data_i
);
  import lrurp_pkg::*;
  `include "lru_replacement_policy_macros.svh"

  localparam int unsigned IdxW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WAYS + 1);
  localparam int unsigned RstWays = (ResetWays > MAX_WAYS) ? MAX_WAYS : ResetWays;

  logic [CntW-1:0]     ways_q, ways_d;
  logic [MAX_WAYS-1:0] present_q, present_d;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_bad_q, s1_bad_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                cfg_wr;
  logic                in_acc;
  logic                s1_move;
  logic                bad;
  logic                touch_en;
  cell_ctrl_t          ctrl;

  logic [MAX_WAYS:0]   carry;
  way_t                cell_way [MAX_WAYS];
  logic [MAX_WAYS-1:0] cell_valid;
  logic [MAX_WAYS-1:0] last_vec;

  logic                full;
  way_t                lru_way;
  logic [IdxW-1:0]     free_idx;

  assign cfg_ready_o = !s1_valid_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign s1_move     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (!s1_valid_q || s1_move) && !cfg_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;

  assign bad      = (in_data_i.operation == OpTouch) &&
                    (32'(in_data_i.way) >= 32'(ways_q));
  assign touch_en = in_acc && (in_data_i.operation == OpTouch) && !bad;

  always_comb begin
    ctrl.clear = cfg_wr;
    ctrl.shift = touch_en;
    ctrl.way   = in_data_i.way;
  end

  assign carry[0] = 1'b1;

  for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
    way_t prev_way;
    if (i == 0) begin : g_head
      assign prev_way = in_data_i.way;
    end else begin : g_body
      assign prev_way = cell_way[i-1];
    end
    lrurp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_way_i (prev_way),
      .carry_i    (carry[i]),
      .carry_o    (carry[i+1]),
      .way_o      (cell_way[i]),
      .valid_o    (cell_valid[i])
    );
    assign last_vec[i] = (32'(ways_q) == 32'(i + 1));
  end

  always_comb begin
    lru_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (last_vec[i]) begin
        lru_way = lru_way | cell_way[i];
      end
    end
    full = |(cell_valid & last_vec);
  end

  always_comb begin
    free_idx = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (!present_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      ways_d = CntW'(1);
    end else if (32'(cfg_data_i) > MAX_WAYS) begin
      ways_d = CntW'(MAX_WAYS);
    end else begin
      ways_d = CntW'(cfg_data_i);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      present_d[i] = !cfg_wr &&
                     (present_q[i] || (touch_en && (32'(in_data_i.way) == 32'(i))));
    end
    s1_valid_d  = in_acc || (s1_valid_q && !s1_move);
    s1_bad_d    = in_acc ? bad : s1_bad_q;
    out_valid_d = s1_move || (out_valid_q && !out_ready_i);
    out_d       = out_q;
    if (s1_move) begin
      out_d.bad_way = s1_bad_q;
      if (full) begin
        out_d.victim     = lru_way;
        out_d.from_empty = 1'b0;
      end else begin
        out_d.victim     = way_t'(free_idx);
        out_d.from_empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q      <= CntW'(RstWays);
      present_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        ways_q <= ways_d;
      end
      present_q   <= present_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_q <= s1_bad_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LRURP_ASSERT_SAME(a_valid_prefix, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0)
  `LRURP_ASSERT_SAME(a_count_match, 1'b1, $countones(cell_valid) == $countones(present_q))
  `LRURP_ASSERT_SAME(a_no_overflow, touch_en, !carry[MAX_WAYS])
  `LRURP_ASSERT_NEXT(a_cfg_empties, cfg_wr, (cell_valid == '0) && (present_q == '0))
  `LRURP_ASSERT_NEXT(a_bad_keeps, in_acc && bad, $stable(cell_valid) && $stable(present_q))

endmodule

/* hdl/lrurp_cell.sv */
// one entry of the recency list, loading from its more recent neighbor
`timescale 1ns / 1ps
module lrurp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrurp_pkg::cell_ctrl_t ctrl_i,
  input  lrurp_pkg::way_t     prev_way_i,
  input  logic                carry_i,
  output logic                carry_o,
  output lrurp_pkg::way_t     way_o,
  output logic                valid_o
);
  import lrurp_pkg::*;

  way_t way_q, way_d;
  logic valid_q, valid_d;
  logic hit;
  logic load;

  always_comb begin
    hit     = valid_q && (way_q == ctrl_i.way);
    load    = ctrl_i.shift && carry_i;
    carry_o = carry_i && valid_q && !hit;
    way_d   = load ? prev_way_i : way_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q | load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    way_q <= way_d;
  end

  assign way_o   = way_q;
  assign valid_o = valid_q;

endmodule
